FILE: sv/npm_pkg.sv
package npm_pkg;

    typedef struct packed {
        logic [23:0] red;
        logic [23:0] green;
        logic [23:0] blue;
        logic [39:0] count;
    } entry_t;

    typedef struct packed {
        logic shift;
        logic wr;
    } cell_ctrl_t;

    localparam logic [1:0] OP_LOAD  = 2'd0;
    localparam logic [1:0] OP_MERGE = 2'd1;

    localparam logic [39:0] COUNT_MAX = 40'hff_ffff_ffff;

    // (v + 0x8000) >> 16, saturated to 255
    function automatic logic [7:0] round8(input logic [23:0] v);
        logic [24:0] s;
        begin
            s = {1'b0, v} + 25'h8000;
            round8 = s[24] ? 8'hff : s[23:16];
        end
    endfunction

endpackage

FILE: sv/npm_cell.sv
// One palette entry; passes its contents down the ring when shifting.
module npm_cell (
    input  logic                aclk,
    input  npm_pkg::cell_ctrl_t ctrl,
    input  npm_pkg::entry_t     wr_data,
    input  npm_pkg::entry_t     nb_data,
    output npm_pkg::entry_t     q
);
    npm_pkg::entry_t ent_reg;
    npm_pkg::entry_t ent_next;

    always_comb begin
        ent_next = ent_reg;
        if (ctrl.wr) begin
            ent_next = wr_data;
        end else if (ctrl.shift) begin
            ent_next = nb_data;
        end
    end

    always_ff @(posedge aclk) begin
        ent_reg <= ent_next;
    end

    assign q = ent_reg;
endmodule

FILE: sv/npm_mean_lane.sv
// Weighted mean of one component: shift-add product, then restoring divide.
module npm_mean_lane (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        start,
    input  logic [23:0] old,
    input  logic [39:0] cnt,
    input  logic [7:0]  in8,
    input  logic [31:0] wgt,
    input  logic [40:0] tot,
    output logic        done,
    output logic [23:0] q
);
    typedef enum logic [1:0] {L_IDLE, L_MUL, L_DIV} lane_state_t;

    lane_state_t state_reg;
    logic [64:0] acc_reg;
    logic [63:0] mcand_reg;
    logic [39:0] mplier_reg;
    logic [63:0] dvs_reg;
    logic [5:0]  step_reg;
    logic [23:0] q_reg;
    logic        done_reg;
    logic [39:0] wprod;

    assign wprod = 40'(wgt) * 40'(in8);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= L_IDLE;
            done_reg  <= 1'b0;
        end else begin
            done_reg <= 1'b0;
            case (state_reg)
                L_IDLE: begin
                    if (start) begin
                        acc_reg    <= {9'b0, wprod, 16'b0};
                        mcand_reg  <= {40'b0, old};
                        mplier_reg <= cnt;
                        dvs_reg    <= {tot, 23'b0};
                        step_reg   <= 6'd39;
                        state_reg  <= L_MUL;
                    end
                end
                L_MUL: begin
                    if (mplier_reg[0]) begin
                        acc_reg <= acc_reg + {1'b0, mcand_reg};
                    end
                    mcand_reg  <= {mcand_reg[62:0], 1'b0};
                    mplier_reg <= {1'b0, mplier_reg[39:1]};
                    if (step_reg == 6'd0) begin
                        step_reg  <= 6'd23;
                        state_reg <= L_DIV;
                    end else begin
                        step_reg <= step_reg - 6'd1;
                    end
                end
                L_DIV: begin
                    if (acc_reg >= {1'b0, dvs_reg}) begin
                        acc_reg <= acc_reg - {1'b0, dvs_reg};
                        q_reg   <= {q_reg[22:0], 1'b1};
                    end else begin
                        q_reg <= {q_reg[22:0], 1'b0};
                    end
                    dvs_reg <= {1'b0, dvs_reg[63:1]};
                    if (step_reg == 6'd0) begin
                        done_reg  <= 1'b1;
                        state_reg <= L_IDLE;
                    end else begin
                        step_reg <= step_reg - 6'd1;
                    end
                end
                default: state_reg <= L_IDLE;
            endcase
        end
    end

    assign done = done_reg;
    assign q    = q_reg;
endmodule

FILE: sv/nearest_palette_merge_top.sv
// Palette table held in a ring of ENTRIES cells that rotates one place per
// cycle while seeking or scanning; only the cell at the head of the ring is
// read or written. A request is taken when the block is idle, and its one
// result waits in an output register, so a new request can be taken while a
// result is still pending. Load and read rotate the ring to the entry, then
// write or read it. Merge rotates to entry 0, scans the active entries one
// per cycle, rotates to the winner, then runs the mean lanes (shift-add
// multiply, then restoring divide) unless the new total count is zero.
// Entries hold no defined value until loaded; merge must only see loaded ones.
module nearest_palette_merge_top #(
    parameter int ENTRIES = 256
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        cfg_wr_en,
    input  logic [8:0]  cfg_wr_data,   // active_entries
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [63:0] s_tdata,       // entry_index, red, green, blue, weight
    input  logic [1:0]  s_tuser,       // opcode
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [71:0] m_tdata        // out_index, out_red, out_green, out_blue,
                                       // out_count
);
    localparam int IW = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
    localparam logic [8:0] LIM_MAX = 9'((ENTRIES < 256) ? ENTRIES : 256);
    localparam logic [IW-1:0] HEAD_LAST = IW'(ENTRIES - 1);

    typedef enum logic [2:0] {
        ST_IDLE, ST_SEEK, ST_SCAN, ST_DRAIN, ST_MSEEK, ST_MEAN, ST_OUT
    } state_t;

    state_t state_reg;

    logic [8:0]  active_reg;
    logic [1:0]  op_reg;
    logic [7:0]  idx_reg;
    logic [7:0]  r_reg, g_reg, b_reg;
    logic [31:0] w_reg;
    logic [IW-1:0] head_reg;
    logic [IW-1:0] tgt_reg;
    logic [8:0]  scan_reg;

    // distance pipeline
    logic        p_valid_reg;
    logic [IW-1:0] p_idx_reg;
    logic [47:0] sq_r_reg, sq_g_reg, sq_b_reg;
    logic        best_any_reg;
    logic [49:0] best_d_reg;
    logic [IW-1:0] best_reg;

    logic [40:0] tot_reg;

    // staged and registered result
    logic [71:0] res_reg;
    logic        m_valid_reg;
    logic [71:0] m_data_reg;

    // ring
    npm_pkg::entry_t cell_q [ENTRIES];
    npm_pkg::entry_t wr_data;
    logic            shift_en;
    logic            wr_en;

    genvar gi;
    generate
        for (gi = 0; gi < ENTRIES; gi++) begin : g_cell
            localparam int NB = (gi + 1) % ENTRIES;
            npm_pkg::cell_ctrl_t ctrl;
            assign ctrl.shift = shift_en;
            assign ctrl.wr    = (gi == 0) ? wr_en : 1'b0;
            npm_cell u_cell (
                .aclk    (aclk),
                .ctrl    (ctrl),
                .wr_data (wr_data),
                .nb_data (cell_q[NB]),
                .q       (cell_q[gi])
            );
        end
    endgenerate

    npm_pkg::entry_t head_ent;
    assign head_ent = cell_q[0];

    logic [8:0] lim;
    always_comb begin
        lim = active_reg;
        if (lim == 9'd0) lim = 9'd1;
        if (lim > LIM_MAX) lim = LIM_MAX;
    end

    logic [IW-1:0] head_inc;
    assign head_inc = (head_reg == HEAD_LAST) ? '0 : head_reg + IW'(1);

    // distance of the head entry
    logic [24:0] dr, dg, db;
    logic [23:0] ar, ag, ab;
    assign dr = {1'b0, head_ent.red}   - {1'b0, r_reg, 16'b0};
    assign dg = {1'b0, head_ent.green} - {1'b0, g_reg, 16'b0};
    assign db = {1'b0, head_ent.blue}  - {1'b0, b_reg, 16'b0};
    assign ar = dr[24] ? 24'(-dr) : dr[23:0];
    assign ag = dg[24] ? 24'(-dg) : dg[23:0];
    assign ab = db[24] ? 24'(-db) : db[23:0];

    logic [49:0] dsum;
    assign dsum = {2'b0, sq_r_reg} + {2'b0, sq_g_reg} + {2'b0, sq_b_reg};

    logic [40:0] tot_now;
    assign tot_now = {1'b0, head_ent.count} + {9'b0, w_reg};

    // mean lanes; operands are taken from the head entry on the start cycle
    logic        lane_start;
    logic [2:0]  lane_done;
    logic [23:0] q_r, q_g, q_b;

    npm_mean_lane u_lane_r (
        .aclk(aclk), .aresetn(aresetn), .start(lane_start), .old(head_ent.red),
        .cnt(head_ent.count), .in8(r_reg), .wgt(w_reg), .tot(tot_now),
        .done(lane_done[0]), .q(q_r)
    );
    npm_mean_lane u_lane_g (
        .aclk(aclk), .aresetn(aresetn), .start(lane_start), .old(head_ent.green),
        .cnt(head_ent.count), .in8(g_reg), .wgt(w_reg), .tot(tot_now),
        .done(lane_done[1]), .q(q_g)
    );
    npm_mean_lane u_lane_b (
        .aclk(aclk), .aresetn(aresetn), .start(lane_start), .old(head_ent.blue),
        .cnt(head_ent.count), .in8(b_reg), .wgt(w_reg), .tot(tot_now),
        .done(lane_done[2]), .q(q_b)
    );

    logic in_range;
    assign in_range = ({3'b0, s_tdata[7:0]} < 11'(ENTRIES));

    // ring control and write data for the head cell
    always_comb begin
        shift_en   = 1'b0;
        wr_en      = 1'b0;
        wr_data    = head_ent;
        lane_start = 1'b0;
        case (state_reg)
            ST_SEEK: begin
                if (head_reg != tgt_reg) begin
                    shift_en = 1'b1;
                end else if (op_reg == npm_pkg::OP_LOAD) begin
                    wr_en   = 1'b1;
                    wr_data = '{red: {r_reg, 16'b0}, green: {g_reg, 16'b0},
                                blue: {b_reg, 16'b0}, count: {8'b0, w_reg}};
                end
            end
            ST_SCAN:  shift_en = 1'b1;
            ST_MSEEK: begin
                if (head_reg != tgt_reg) begin
                    shift_en = 1'b1;
                end else begin
                    lane_start = (tot_now != 41'd0);
                end
            end
            ST_MEAN: begin
                if (&lane_done) begin
                    wr_en   = 1'b1;
                    wr_data = '{red: q_r, green: q_g, blue: q_b,
                                count: tot_reg[40] ? npm_pkg::COUNT_MAX : tot_reg[39:0]};
                end
            end
            default: ;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= ST_IDLE;
            active_reg   <= 9'd256;
            head_reg     <= '0;
            p_valid_reg  <= 1'b0;
            best_any_reg <= 1'b0;
            m_valid_reg  <= 1'b0;
        end else begin
            if (cfg_wr_en) active_reg <= cfg_wr_data;
            if (shift_en) head_reg <= head_inc;
            if (m_valid_reg && m_tready) m_valid_reg <= 1'b0;

            // distance compare stage
            p_valid_reg <= 1'b0;
            if (p_valid_reg) begin
                if (!best_any_reg || dsum < best_d_reg) begin
                    best_any_reg <= 1'b1;
                    best_d_reg   <= dsum;
                    best_reg     <= p_idx_reg;
                end
            end

            case (state_reg)
                ST_IDLE: begin
                    if (s_tvalid) begin
                        op_reg  <= s_tuser;
                        idx_reg <= s_tdata[7:0];
                        r_reg   <= s_tdata[15:8];
                        g_reg   <= s_tdata[23:16];
                        b_reg   <= s_tdata[31:24];
                        w_reg   <= s_tdata[63:32];
                        if (s_tuser == npm_pkg::OP_MERGE) begin
                            tgt_reg   <= '0;
                            state_reg <= ST_SEEK;
                        end else if (in_range) begin
                            tgt_reg   <= IW'(s_tdata[7:0]);
                            state_reg <= ST_SEEK;
                        end else begin
                            res_reg   <= {64'b0, s_tdata[7:0]};
                            state_reg <= ST_OUT;
                        end
                    end
                end
                ST_SEEK: begin
                    if (head_reg == tgt_reg) begin
                        if (op_reg == npm_pkg::OP_MERGE) begin
                            scan_reg     <= 9'd0;
                            best_any_reg <= 1'b0;
                            state_reg    <= ST_SCAN;
                        end else if (op_reg == npm_pkg::OP_LOAD) begin
                            res_reg   <= {{8'b0, w_reg}, b_reg, g_reg, r_reg, idx_reg};
                            state_reg <= ST_OUT;
                        end else begin
                            res_reg <= {head_ent.count, npm_pkg::round8(head_ent.blue),
                                        npm_pkg::round8(head_ent.green),
                                        npm_pkg::round8(head_ent.red), idx_reg};
                            state_reg <= ST_OUT;
                        end
                    end
                end
                ST_SCAN: begin
                    p_valid_reg <= 1'b1;
                    p_idx_reg   <= head_reg;
                    sq_r_reg    <= ar * ar;
                    sq_g_reg    <= ag * ag;
                    sq_b_reg    <= ab * ab;
                    scan_reg    <= scan_reg + 9'd1;
                    if (scan_reg == lim - 9'd1) state_reg <= ST_DRAIN;
                end
                ST_DRAIN: begin
                    if (!p_valid_reg) begin
                        tgt_reg   <= best_reg;
                        state_reg <= ST_MSEEK;
                    end
                end
                ST_MSEEK: begin
                    if (head_reg == tgt_reg) begin
                        tot_reg <= tot_now;
                        if (tot_now == 41'd0) begin
                            res_reg <= {head_ent.count, npm_pkg::round8(head_ent.blue),
                                        npm_pkg::round8(head_ent.green),
                                        npm_pkg::round8(head_ent.red), 8'(head_reg)};
                            state_reg <= ST_OUT;
                        end else begin
                            state_reg <= ST_MEAN;
                        end
                    end
                end
                ST_MEAN: begin
                    if (&lane_done) begin
                        res_reg <= {tot_reg[40] ? npm_pkg::COUNT_MAX : tot_reg[39:0],
                                    npm_pkg::round8(q_b), npm_pkg::round8(q_g),
                                    npm_pkg::round8(q_r), 8'(head_reg)};
                        state_reg <= ST_OUT;
                    end
                end
                ST_OUT: begin
                    if (!m_valid_reg || m_tready) begin
                        m_data_reg  <= res_reg;
                        m_valid_reg <= 1'b1;
                        state_reg   <= ST_IDLE;
                    end
                end
                default: state_reg <= ST_IDLE;
            endcase
        end
    end

    assign s_tready = (state_reg == ST_IDLE);
    assign m_tvalid = m_valid_reg;
    assign m_tdata  = m_data_reg;
endmodule
